### rtl/rqt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqt_pkg
// Shared types and constants of the retransmit queue.
// ----------------------------------------------------------------------------
package rqt_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 16;

    localparam int SEQ_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int KIND_W   = 8;
    localparam int RETRY_W  = 4;
    localparam int TMO_W    = 8;
    localparam int REQ_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 4'd3;
    localparam logic [TMO_W-1:0]   TIMEOUT_RST     = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd1;

    localparam logic [REQ_W-1:0] REQ_ADD   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ACK   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd4;

    localparam logic [1:0] RK_DONE   = 2'd0;
    localparam logic [1:0] RK_RESEND = 2'd1;
    localparam logic [1:0] RK_FAIL   = 2'd2;
    localparam logic [1:0] RK_QUERY  = 2'd3;

    typedef enum logic [2:0] {
        RES_DONE,
        RES_FULL,
        RES_ACK_HIT,
        RES_Q_HIT,
        RES_Q_MISS,
        RES_RESEND,
        RES_FAIL
    } res_sel_t;

    typedef struct packed {
        logic       req_load;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_next;
        logic       wr_add;
        logic       wr_shift;
        logic       head_eval;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       cnt_clr;
        logic       time_inc;
        logic       out_load;
        res_sel_t   out_sel;
        logic       out_last;
    } rqt_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             empty;
        logic             scan_end;
        logic             match;
        logic             shift_end;
        logic             resend;
        logic             fail;
        logic             out_free;
    } rqt_sts_t;

endpackage
`default_nettype wire

### rtl/rqt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/rqt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqt_dp
// Datapath: entry RAM, count, time, config registers and result register.
// ----------------------------------------------------------------------------
module rqt_dp #(
    parameter int QUEUE_DEPTH = rqt_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH  = rqt_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rqt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rqt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [rqt_pkg::REQ_W-1:0]         req_type,
    input  wire logic [rqt_pkg::SEQ_W-1:0]         packet_seq,
    input  wire logic [rqt_pkg::HANDLE_W-1:0]      packet_handle,
    input  wire logic [rqt_pkg::KIND_W-1:0]        packet_kind,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic      [1:0]                        result_kind,
    output logic                                   found,
    output logic                                   full_res,
    output logic      [rqt_pkg::HANDLE_W-1:0]      out_handle,
    output logic      [rqt_pkg::KIND_W-1:0]        out_kind,
    output logic      [rqt_pkg::RETRY_W-1:0]       out_retry,
    output logic                                   last,
    input  wire rqt_pkg::rqt_cmd_t                 cmd,
    output rqt_pkg::rqt_sts_t                      sts
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = rqt_pkg::SEQ_W;
    localparam int HW = rqt_pkg::HANDLE_W;
    localparam int KW = rqt_pkg::KIND_W;
    localparam int RW = rqt_pkg::RETRY_W;
    localparam int EW = SW + HW + KW + RW + TIME_WIDTH;

    typedef struct packed {
        logic [SW-1:0]         seq;
        logic [HW-1:0]         handle;
        logic [KW-1:0]         kind;
        logic [RW-1:0]         retries;
        logic [TIME_WIDTH-1:0] stamp;
    } entry_t;

    logic [rqt_pkg::REQ_W-1:0] req_reg;
    logic [SW-1:0]             seq_reg;
    logic [HW-1:0]             handle_reg;
    logic [KW-1:0]             kind_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             idx_reg;
    logic [TIME_WIDTH-1:0]     now_reg;
    logic [RW-1:0]             max_reg;
    logic [rqt_pkg::TMO_W-1:0] tmo_reg;
    logic [HW-1:0]             head_handle_reg;
    logic [KW-1:0]             head_kind_reg;
    logic [RW-1:0]             head_retry_reg;
    logic                      out_valid_reg;
    logic [1:0]                rk_reg;
    logic                      found_reg;
    logic                      full_reg;
    logic [HW-1:0]             oh_reg;
    logic [KW-1:0]             ok_reg;
    logic [RW-1:0]             or_reg;
    logic                      last_reg;

    entry_t                rd_ent;
    entry_t                wr_ent;
    logic [EW-1:0]         rdata;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [CW:0]           idx_p1;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  resend;
    logic [RW-1:0]         new_retry;

    assign rd_ent    = entry_t'(rdata);
    assign idx_p1    = {1'b0, idx_reg} + {{CW{1'b0}}, 1'b1};
    assign raddr     = cmd.rd_next ? idx_p1[AW-1:0] : idx_reg[AW-1:0];
    assign elapsed   = now_reg - rd_ent.stamp;
    assign resend    = (rd_ent.retries < max_reg) &&
                       (elapsed >= TIME_WIDTH'(tmo_reg));
    assign new_retry = resend ? (rd_ent.retries + 1'b1) : rd_ent.retries;

    always_comb
    begin
        we     = cmd.wr_add || cmd.wr_shift || (cmd.head_eval && resend);
        waddr  = idx_reg[AW-1:0];
        wr_ent = rd_ent;
        priority if (cmd.wr_add)
        begin
            waddr          = count_reg[AW-1:0];
            wr_ent.seq     = seq_reg;
            wr_ent.handle  = handle_reg;
            wr_ent.kind    = kind_reg;
            wr_ent.retries = '0;
            wr_ent.stamp   = now_reg;
        end
        else if (cmd.head_eval)
        begin
            waddr          = '0;
            wr_ent.retries = new_retry;
            wr_ent.stamp   = now_reg;
        end
        else
        begin
            waddr = idx_reg[AW-1:0];
        end
    end

    rqt_ram #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(EW'(wr_ent)),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        sts.req       = req_reg;
        sts.full      = (count_reg == CW'(QUEUE_DEPTH));
        sts.empty     = (count_reg == '0);
        sts.scan_end  = (idx_reg >= count_reg);
        sts.match     = (rd_ent.seq == seq_reg);
        sts.shift_end = (idx_p1 >= {1'b0, count_reg});
        sts.resend    = resend;
        sts.fail      = (new_retry >= max_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            now_reg       <= '0;
            max_reg       <= rqt_pkg::MAX_RETRIES_RST;
            tmo_reg       <= rqt_pkg::TIMEOUT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == rqt_pkg::CFG_MAX_RETRIES)
            begin
                max_reg <= cfg_data[RW-1:0];
            end
            if (cfg_we && cfg_index == rqt_pkg::CFG_TIMEOUT)
            begin
                tmo_reg <= cfg_data;
            end
            if (cmd.cnt_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_p1[CW-1:0];
            end
            if (cmd.time_inc)
            begin
                now_reg <= now_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_reg    <= req_type;
            seq_reg    <= packet_seq;
            handle_reg <= packet_handle;
            kind_reg   <= packet_kind;
        end
        if (cmd.head_eval)
        begin
            head_handle_reg <= rd_ent.handle;
            head_kind_reg   <= rd_ent.kind;
            head_retry_reg  <= new_retry;
        end
        if (cmd.out_load)
        begin
            rk_reg    <= rqt_pkg::RK_DONE;
            found_reg <= 1'b0;
            full_reg  <= 1'b0;
            oh_reg    <= '0;
            ok_reg    <= '0;
            or_reg    <= '0;
            last_reg  <= cmd.out_last;
            unique case (cmd.out_sel)
                rqt_pkg::RES_DONE:    rk_reg <= rqt_pkg::RK_DONE;
                rqt_pkg::RES_FULL:    full_reg <= 1'b1;
                rqt_pkg::RES_ACK_HIT: found_reg <= 1'b1;
                rqt_pkg::RES_Q_HIT:
                begin
                    rk_reg    <= rqt_pkg::RK_QUERY;
                    found_reg <= 1'b1;
                end
                rqt_pkg::RES_Q_MISS:  rk_reg <= rqt_pkg::RK_QUERY;
                rqt_pkg::RES_RESEND,
                rqt_pkg::RES_FAIL:
                begin
                    rk_reg <= (cmd.out_sel == rqt_pkg::RES_FAIL) ?
                              rqt_pkg::RK_FAIL : rqt_pkg::RK_RESEND;
                    oh_reg <= head_handle_reg;
                    ok_reg <= head_kind_reg;
                    or_reg <= head_retry_reg;
                end
                default:              rk_reg <= rqt_pkg::RK_DONE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = rk_reg;
    assign found       = found_reg;
    assign full_res    = full_reg;
    assign out_handle  = oh_reg;
    assign out_kind    = ok_reg;
    assign out_retry   = or_reg;
    assign last        = last_reg;
endmodule
`default_nettype wire

### rtl/rqt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqt_ctrl
// Request sequencer: dispatch, scan, shift, head check and result emit.
// ----------------------------------------------------------------------------
module rqt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rqt_pkg::rqt_sts_t sts,
    output rqt_pkg::rqt_cmd_t      cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SC_RD,
        S_SC_CMP,
        S_SH_CHK,
        S_SH_WR,
        S_T_RD,
        S_T_EVAL,
        S_EMIT
    } state_t;

    state_t            state_reg;
    rqt_pkg::res_sel_t sel_reg;
    rqt_pkg::res_sel_t sel2_reg;
    logic              two_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.out_sel  = sel_reg;
        cmd.out_last = !two_reg;
        cmd.req_load = in_valid && in_ready;
        unique case (state_reg)
            S_IDLE: ;
            S_DISP:
            begin
                cmd.idx_clr = 1'b1;
                if (sts.req == rqt_pkg::REQ_ADD && !sts.full)
                begin
                    cmd.wr_add  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                end
                if (sts.req == rqt_pkg::REQ_CLEAR)
                begin
                    cmd.cnt_clr = 1'b1;
                end
                if (sts.req == rqt_pkg::REQ_TICK)
                begin
                    cmd.time_inc = 1'b1;
                end
            end
            S_SC_RD: ;
            S_SC_CMP:    cmd.idx_inc = !sts.match;
            S_SH_CHK:
            begin
                cmd.rd_next = 1'b1;
                cmd.cnt_dec = sts.shift_end;
            end
            S_SH_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            S_T_RD: ;
            S_T_EVAL:    cmd.head_eval = 1'b1;
            S_EMIT:      cmd.out_load = sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= rqt_pkg::RES_DONE;
            sel2_reg  <= rqt_pkg::RES_DONE;
            two_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    two_reg <= 1'b0;
                    sel_reg <= rqt_pkg::RES_DONE;
                    if (in_valid)
                    begin
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    state_reg <= S_EMIT;
                    priority if (sts.req == rqt_pkg::REQ_ADD)
                    begin
                        sel_reg <= sts.full ? rqt_pkg::RES_FULL : rqt_pkg::RES_DONE;
                    end
                    else if (sts.req == rqt_pkg::REQ_ACK ||
                             sts.req == rqt_pkg::REQ_QUERY)
                    begin
                        state_reg <= S_SC_RD;
                    end
                    else if (sts.req == rqt_pkg::REQ_TICK && !sts.empty)
                    begin
                        state_reg <= S_T_RD;
                    end
                    else
                    begin
                        sel_reg <= rqt_pkg::RES_DONE;
                    end
                end
                S_SC_RD:
                begin
                    if (sts.scan_end)
                    begin
                        sel_reg   <= (sts.req == rqt_pkg::REQ_QUERY) ?
                                     rqt_pkg::RES_Q_MISS : rqt_pkg::RES_DONE;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SC_CMP;
                    end
                end
                S_SC_CMP:
                begin
                    priority if (!sts.match)
                    begin
                        state_reg <= S_SC_RD;
                    end
                    else if (sts.req == rqt_pkg::REQ_QUERY)
                    begin
                        sel_reg   <= rqt_pkg::RES_Q_HIT;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        sel_reg   <= rqt_pkg::RES_ACK_HIT;
                        state_reg <= S_SH_CHK;
                    end
                end
                S_SH_CHK:    state_reg <= sts.shift_end ? S_EMIT : S_SH_WR;
                S_SH_WR:     state_reg <= S_SH_CHK;
                S_T_RD:      state_reg <= S_T_EVAL;
                S_T_EVAL:
                begin
                    priority if (sts.fail)
                    begin
                        sel_reg   <= sts.resend ? rqt_pkg::RES_RESEND : rqt_pkg::RES_FAIL;
                        sel2_reg  <= rqt_pkg::RES_FAIL;
                        two_reg   <= sts.resend;
                        state_reg <= S_SH_CHK;
                    end
                    else
                    begin
                        sel_reg   <= sts.resend ? rqt_pkg::RES_RESEND : rqt_pkg::RES_DONE;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (sts.out_free)
                    begin
                        if (two_reg)
                        begin
                            sel_reg <= sel2_reg;
                            two_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/retransmit_queue_timeout_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// retransmit_queue_timeout_top
// Ordered retransmit queue with per-entry retry count and timeout stamp.
// ----------------------------------------------------------------------------
//   in_* carries one request (add, ack, query, clear, tick) per handshake;
//   out_* returns one or two results per request, 'last' marks the final one.
//   cfg_we/cfg_index/cfg_data write max_retries (index 0) and timeout_ticks
//   (index 1); other indexes are dropped. Write only when idle.
//   One request in flight; in_ready is high only when idle, so no new
//   request is taken until the last result of the one before is loaded.
//   Each request is dispatched, then its result is emitted. A tick on a
//   busy queue first reads and evaluates the head; query and ack scan the
//   entries in order up to a match or the count; an ack hit and a failed
//   head then shift the entries behind it down. A second tick result loads
//   at the edge that takes the first one. A stalled receiver holds the
//   sequencer in its emit state, so no new request is taken meanwhile.
//   Reset: queue empty, time zero, max_retries 3, timeout_ticks 5; the
//   entry RAM is not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
module retransmit_queue_timeout_top #(
    parameter int QUEUE_DEPTH = rqt_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH  = rqt_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rqt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rqt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [rqt_pkg::REQ_W-1:0]      req_type,
    input  wire logic [rqt_pkg::SEQ_W-1:0]      packet_seq,
    input  wire logic [rqt_pkg::HANDLE_W-1:0]   packet_handle,
    input  wire logic [rqt_pkg::KIND_W-1:0]     packet_kind,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [1:0]                     result_kind,
    output logic                                found,
    output logic                                full_res,
    output logic      [rqt_pkg::HANDLE_W-1:0]   out_handle,
    output logic      [rqt_pkg::KIND_W-1:0]     out_kind,
    output logic      [rqt_pkg::RETRY_W-1:0]    out_retry,
    output logic                                last
);
    rqt_pkg::rqt_cmd_t cmd;
    rqt_pkg::rqt_sts_t sts;

    // sequencer
    rqt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // queue storage, timers and result register
    rqt_dp #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .packet_seq   (packet_seq),
        .packet_handle(packet_handle),
        .packet_kind  (packet_kind),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .result_kind  (result_kind),
        .found        (found),
        .full_res     (full_res),
        .out_handle   (out_handle),
        .out_kind     (out_kind),
        .out_retry    (out_retry),
        .last         (last),
        .cmd          (cmd),
        .sts          (sts)
    );

`ifndef NO_ASSERTIONS
    // one request in flight: acceptance closes the input
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while busy");

    // never append to a full queue
    a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        sts.full |-> !cmd.wr_add)
        else $error("add into full queue");

    // a result is only loaded when the output register is free
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result overwrote pending output");
`endif
endmodule
`default_nettype wire

### bench/tb_retransmit_queue_timeout_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_retransmit_queue_timeout_top
// Self-checking bench for the retransmit queue with timeout.
// A scoreboard predicts the results of every accepted request and
// compares them, field by field and in order, with what the block returns.
// ----------------------------------------------------------------------------
module tb_retransmit_queue_timeout_top;

    localparam int DEPTH     = 16;
    localparam int TW        = 9;       // narrow time so the wrap is reached
    localparam int WATCHDOG  = 20000;

    typedef struct {
        logic [1:0]                   kind;
        logic                         fnd;
        logic                         full;
        logic [rqt_pkg::HANDLE_W-1:0] handle;
        logic [rqt_pkg::KIND_W-1:0]   pkind;
        logic [rqt_pkg::RETRY_W-1:0]  retry;
        logic                         lst;
    } result_t;

    // Scoreboard: own copy of the queue, clock and registers.
    class retx_scoreboard;
        logic [rqt_pkg::SEQ_W-1:0]    q_seq[DEPTH];
        logic [rqt_pkg::HANDLE_W-1:0] q_handle[DEPTH];
        logic [rqt_pkg::KIND_W-1:0]   q_kind[DEPTH];
        logic [rqt_pkg::RETRY_W-1:0]  q_retry[DEPTH];
        logic [TW-1:0]                q_stamp[DEPTH];
        int                           count;
        logic [TW-1:0]                now;
        logic [rqt_pkg::RETRY_W-1:0]  retry_limit;
        logic [rqt_pkg::TMO_W-1:0]    timeout;
        result_t                      pending[$];
        int                           errors;
        int                           checked;
        int                           n_resend, n_fail, n_full, n_hit;

        function new();
            count = 0; now = '0; retry_limit = rqt_pkg::MAX_RETRIES_RST;
            timeout = rqt_pkg::TIMEOUT_RST; errors = 0; checked = 0;
            n_resend = 0; n_fail = 0; n_full = 0; n_hit = 0;
        endfunction

        function void set_reg(logic [rqt_pkg::CFG_IDX_W-1:0] idx,
                              logic [rqt_pkg::CFG_DATA_W-1:0] val);
            if (idx == rqt_pkg::CFG_MAX_RETRIES) retry_limit = val[rqt_pkg::RETRY_W-1:0];
            else if (idx == rqt_pkg::CFG_TIMEOUT) timeout = val;
        endfunction

        function void push(logic [1:0] k, logic f, logic fl,
                           logic [rqt_pkg::HANDLE_W-1:0] h,
                           logic [rqt_pkg::KIND_W-1:0] pk,
                           logic [rqt_pkg::RETRY_W-1:0] r, logic l);
            result_t e;
            e.kind = k; e.fnd = f; e.full = fl; e.handle = h;
            e.pkind = pk; e.retry = r; e.lst = l;
            pending.push_back(e);
        endfunction

        function void remove_at(int i);
            for (int j = i; j + 1 < count; j++) begin
                q_seq[j] = q_seq[j+1]; q_handle[j] = q_handle[j+1];
                q_kind[j] = q_kind[j+1]; q_retry[j] = q_retry[j+1];
                q_stamp[j] = q_stamp[j+1];
            end
            count--;
        endfunction

        function int lookup(logic [rqt_pkg::SEQ_W-1:0] s);
            for (int i = 0; i < count; i++)
                if (q_seq[i] == s) return i;
            return -1;
        endfunction

        function void note_request(logic [rqt_pkg::REQ_W-1:0] rt,
                                   logic [rqt_pkg::SEQ_W-1:0] s,
                                   logic [rqt_pkg::HANDLE_W-1:0] h,
                                   logic [rqt_pkg::KIND_W-1:0] k);
            int idx;
            logic resent;
            case (rt)
                rqt_pkg::REQ_ADD:
                    if (count >= DEPTH) begin
                        push(rqt_pkg::RK_DONE, 0, 1, 0, 0, 0, 1); n_full++;
                    end else begin
                        q_seq[count] = s; q_handle[count] = h; q_kind[count] = k;
                        q_retry[count] = 0; q_stamp[count] = now; count++;
                        push(rqt_pkg::RK_DONE, 0, 0, 0, 0, 0, 1);
                    end
                rqt_pkg::REQ_ACK: begin
                    idx = lookup(s);
                    if (idx >= 0) begin remove_at(idx); n_hit++; end
                    push(rqt_pkg::RK_DONE, idx >= 0, 0, 0, 0, 0, 1);
                end
                rqt_pkg::REQ_QUERY: begin
                    idx = lookup(s);
                    push(rqt_pkg::RK_QUERY, idx >= 0, 0, 0, 0, 0, 1);
                end
                rqt_pkg::REQ_CLEAR: begin
                    count = 0;
                    push(rqt_pkg::RK_DONE, 0, 0, 0, 0, 0, 1);
                end
                rqt_pkg::REQ_TICK: begin
                    now = now + 1'b1;
                    resent = 0;
                    if (count == 0) push(rqt_pkg::RK_DONE, 0, 0, 0, 0, 0, 1);
                    else begin
                        if (q_retry[0] < retry_limit &&
                            TW'(now - q_stamp[0]) >= TW'(timeout)) begin
                            q_retry[0] = q_retry[0] + 1'b1;
                            q_stamp[0] = now;
                            resent = 1;
                        end
                        if (q_retry[0] >= retry_limit) begin
                            if (resent) begin
                                push(rqt_pkg::RK_RESEND, 0, 0, q_handle[0], q_kind[0],
                                     q_retry[0], 0);
                                n_resend++;
                            end
                            push(rqt_pkg::RK_FAIL, 0, 0, q_handle[0], q_kind[0],
                                 q_retry[0], 1);
                            n_fail++;
                            remove_at(0);
                        end else if (resent) begin
                            push(rqt_pkg::RK_RESEND, 0, 0, q_handle[0], q_kind[0],
                                 q_retry[0], 1);
                            n_resend++;
                        end else push(rqt_pkg::RK_DONE, 0, 0, 0, 0, 0, 1);
                    end
                end
                default: push(rqt_pkg::RK_DONE, 0, 0, 0, 0, 0, 1);
            endcase
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result kind=%0d handle=%h",
                             got.kind, got.handle);
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind || got.fnd !== exp_r.fnd ||
                got.full !== exp_r.full || got.handle !== exp_r.handle ||
                got.pkind !== exp_r.pkind || got.retry !== exp_r.retry ||
                got.lst !== exp_r.lst) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: result %0d exp kind=%0d found=%0d full=%0d ",
                              "handle=%h pkind=%h retry=%0d last=%0d | got %0d %0d %0d ",
                              "%h %h %0d %0d"}, checked,
                             exp_r.kind, exp_r.fnd, exp_r.full, exp_r.handle,
                             exp_r.pkind, exp_r.retry, exp_r.lst,
                             got.kind, got.fnd, got.full, got.handle,
                             got.pkind, got.retry, got.lst);
            end
        endfunction
    endclass

    logic                           clk = 0;
    logic                           rst_n = 0;
    logic                           cfg_we = 0;
    logic [rqt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rqt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 0;
    logic                           in_ready;
    logic [rqt_pkg::REQ_W-1:0]      req_type = '0;
    logic [rqt_pkg::SEQ_W-1:0]      packet_seq = '0;
    logic [rqt_pkg::HANDLE_W-1:0]   packet_handle = '0;
    logic [rqt_pkg::KIND_W-1:0]     packet_kind = '0;
    logic                           out_valid;
    logic                           out_ready = 0;
    logic [1:0]                     result_kind;
    logic                           found, full_res, last;
    logic [rqt_pkg::HANDLE_W-1:0]   out_handle;
    logic [rqt_pkg::KIND_W-1:0]     out_kind;
    logic [rqt_pkg::RETRY_W-1:0]    out_retry;

    retransmit_queue_timeout_top #(
        .QUEUE_DEPTH(DEPTH),
        .TIME_WIDTH (TW)
    ) dut (.*);

    always #5 clk = ~clk;

    retx_scoreboard sb = new();

    // Idle percentages per side; phase selects which side is slow.
    int  send_idle_pct = 21;
    int  recv_idle_pct = 72;
    bit  recv_hold = 0;     // long receiver hold-off request
    int  idle_cycles = 0;
    bit  timed_out = 0;

    // Sequence numbers in use, so acks and queries mostly hit.
    logic [rqt_pkg::SEQ_W-1:0] live_seqs[$];

    // Receiver: random stalls, plus a long hold-off stretch when asked.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                result_t r;
                r.kind = result_kind; r.fnd = found; r.full = full_res;
                r.handle = out_handle; r.pkind = out_kind; r.retry = out_retry;
                r.lst = last;
                sb.check_result(r);
            end
            out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: cycles without any handshake.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("watchdog expired, %0d results outstanding", sb.pending.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // One request; valid stays up until accepted. Valid drops only on an
    // idle gap or when the sender stops (drain, register write).
    task automatic send_req(logic [rqt_pkg::REQ_W-1:0] rt,
                            logic [rqt_pkg::SEQ_W-1:0] s,
                            logic [rqt_pkg::HANDLE_W-1:0] h,
                            logic [rqt_pkg::KIND_W-1:0] k);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid      <= 1;
        req_type      <= rt;
        packet_seq    <= s;
        packet_handle <= h;
        packet_kind   <= k;
        do @(posedge clk); while (!in_ready);
        sb.note_request(rt, s, h, k);
        if (rt == rqt_pkg::REQ_ADD) live_seqs.push_back(s);
    endtask

    // Wait until all results are back, plus drain for a failed-head shift.
    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);
    endtask

    task automatic write_reg(logic [rqt_pkg::CFG_IDX_W-1:0] idx,
                             logic [rqt_pkg::CFG_DATA_W-1:0] val);
        in_valid  <= 0;
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 0;
        sb.set_reg(idx, val);
    endtask

    // Random request, mostly well-formed: acks/queries aimed at live entries.
    task automatic random_req();
        int                        pick;
        logic [rqt_pkg::SEQ_W-1:0] s;
        pick = $urandom_range(99);
        s = 16'($urandom);
        if (live_seqs.size() != 0 && $urandom_range(3) != 0)
            s = live_seqs[$urandom_range(live_seqs.size() - 1)];
        if (pick < 30)
            send_req(rqt_pkg::REQ_ADD, 16'($urandom), 16'($urandom), 8'($urandom));
        else if (pick < 45)
            send_req(rqt_pkg::REQ_ACK, s, 16'($urandom), 8'($urandom));
        else if (pick < 55)
            send_req(rqt_pkg::REQ_QUERY, s, 16'($urandom), 8'($urandom));
        else if (pick < 57) begin
            send_req(rqt_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom));
            live_seqs.delete();
        end
        else if (pick < 97)
            send_req(rqt_pkg::REQ_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
        else
            send_req(3'($urandom_range(7, 5)), 16'($urandom), 16'($urandom),
                     8'($urandom));
        if (live_seqs.size() > 40) void'(live_seqs.pop_front());
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, all request types, special cases, default regs.
        send_req(rqt_pkg::REQ_TICK, 16'h0000, 16'h0000, 8'h00);     // empty tick
        send_req(rqt_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_req(rqt_pkg::REQ_ADD, 16'h0000, 16'h0000, 8'h00);
        send_req(rqt_pkg::REQ_QUERY, 16'hFFFF, 16'h0000, 8'h00);
        send_req(rqt_pkg::REQ_QUERY, 16'h1234, 16'hFFFF, 8'hFF);    // query miss
        send_req(rqt_pkg::REQ_ACK, 16'h5555, 16'h0, 8'h0);          // ack miss
        send_req(rqt_pkg::REQ_ACK, 16'h0000, 16'h0, 8'h0);          // ack hit
        send_req(3'd7, 16'hAAAA, 16'h5555, 8'hAA);                  // unknown
        send_req(3'd5, 16'h5555, 16'hAAAA, 8'h55);
        send_req(3'd6, 16'h0, 16'h0, 8'h0);
        for (int i = 0; i < 12; i++)                                // resend, fail
            send_req(rqt_pkg::REQ_TICK, 16'h0, 16'h0, 8'h0);
        send_req(rqt_pkg::REQ_CLEAR, 16'h0, 16'h0, 8'h0);
        drain();

        // Zero retry limit: head fails without a resend. Unused index ignored.
        write_reg(rqt_pkg::CFG_MAX_RETRIES, 8'd0);
        write_reg(rqt_pkg::CFG_TIMEOUT, 8'd0);
        write_reg(2'd3, 8'hFF);
        send_req(rqt_pkg::REQ_ADD, 16'h0101, 16'hBEEF, 8'h5A);
        send_req(rqt_pkg::REQ_TICK, 16'h0, 16'h0, 8'h0);
        drain();

        // Receiver holds off first, stalling the adds; then the queue fills and overflows.
        write_reg(rqt_pkg::CFG_MAX_RETRIES, 8'd15);
        write_reg(rqt_pkg::CFG_TIMEOUT, 8'd255);
        fork
            begin
                recv_hold = 1;
                repeat (300) @(posedge clk);
                recv_hold = 0;
            end
            for (int i = 0; i < DEPTH + 3; i++)
                send_req(rqt_pkg::REQ_ADD, 16'(i), 16'($urandom), 8'($urandom));
        join
        drain();

        // Random phases over several register settings.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin send_idle_pct = 21; recv_idle_pct = 72; end
                1: begin send_idle_pct = 72; recv_idle_pct = 21; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_reg(rqt_pkg::CFG_MAX_RETRIES, ph == 5 ? 8'd15 : 8'($urandom_range(4)));
            write_reg(rqt_pkg::CFG_TIMEOUT, ph == 4 ? 8'd255 : 8'($urandom_range(6)));
            send_req(rqt_pkg::REQ_CLEAR, 16'h0, 16'h0, 8'h0);
            live_seqs.delete();
            for (int i = 0; i < 20; i++) random_req();
            drain();                                 // sender pauses for all results
        end

        // Time wrap: ticks up to just before the wrap, then an entry across the wrap.
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(rqt_pkg::CFG_MAX_RETRIES, 8'd2);
        write_reg(rqt_pkg::CFG_TIMEOUT, 8'd3);
        while (sb.now != TW'((1 << TW) - 2))
            send_req(rqt_pkg::REQ_TICK, 16'h0, 16'h0, 8'h0);
        send_req(rqt_pkg::REQ_ADD, 16'h7777, 16'h1357, 8'h24);
        for (int i = 0; i < 12; i++) send_req(rqt_pkg::REQ_TICK, 16'h0, 16'h0, 8'h0);
        drain();

        $display("covered: %0d results, %0d resends, %0d failures,",
                 sb.checked, sb.n_resend, sb.n_fail);
        $display("         %0d full rejects, %0d ack hits, one time wrap",
                 sb.n_full, sb.n_hit);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### files.f
rtl/rqt_pkg.sv
rtl/rqt_ram.sv
rtl/rqt_dp.sv
rtl/rqt_ctrl.sv
rtl/retransmit_queue_timeout_top.sv
bench/tb_retransmit_queue_timeout_top.sv
